>>> rtl/assert_macros.svh
// Assertion macros for the RTL files; the top level includes them.
// Needs signals clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that holds at every edge outside reset.
`define DBS_CHECK(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("check failed");
// Implication from a trigger to a consequence in the same cycle.
`define DBS_IMPLY(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("implication failed");
`endif

>>> rtl/dbs_pkg.sv
// Package for the digit box selector: sizes, types, register codes, helpers.
// No dependencies.
`default_nettype none
package dbs_pkg;
    localparam int MAX_BOXES  = 64;
    localparam int COORD_BITS = 12;
    localparam int FIELD_W    = 12;
    localparam int REG_W      = 12;
    localparam int IDX_W      = $clog2(MAX_BOXES);
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int CMP_W      = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);

    localparam logic [REG_W-1:0] MIN_H_RST = REG_W'(20);
    localparam logic [REG_W-1:0] MAX_H_RST = REG_W'(90);
    localparam logic [REG_W-1:0] ALIGN_RST = REG_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_H = 2'd0,
        REG_MAX_H = 2'd1,
        REG_ALIGN = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } box_t;

    typedef struct packed {
        box_t box;
        logic pass;
        logic last;
    } entry_t;

    typedef struct packed {
        logic [REG_W-1:0] min_h;
        logic [REG_W-1:0] max_h;
        logic [REG_W-1:0] align;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } back_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRD,
        ST_GWAIT,
        ST_GSCAN,
        ST_ERD,
        ST_EWAIT,
        ST_ESCAN,
        ST_EPUT
    } state_t;

    function automatic logic boxes_align(box_t a, box_t b, logic [REG_W-1:0] align);
        logic [COORD_BITS-1:0] dy;
        logic [COORD_BITS-1:0] dh;
        dy = (a.y > b.y) ? (a.y - b.y) : (b.y - a.y);
        dh = (a.h > b.h) ? (a.h - b.h) : (b.h - a.h);
        return (CMP_W'(dy) < CMP_W'(align)) && (CMP_W'(dh) < CMP_W'(align >> 1));
    endfunction
endpackage
`default_nettype wire

>>> rtl/dbs_front.sv
// Front end: takes candidate box transactions and classifies them by size.
// Depends on dbs_pkg.
`default_nettype none
module dbs_front (
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dbs_pkg::FIELD_W-1:0]   box_x,
    input  wire logic [dbs_pkg::FIELD_W-1:0]   box_y,
    input  wire logic [dbs_pkg::FIELD_W-1:0]   box_width,
    input  wire logic [dbs_pkg::FIELD_W-1:0]   box_height,
    input  wire logic                          frame_end,
    input  wire dbs_pkg::cfg_t                 cfg,
    input  wire dbs_pkg::fifo_stat_t           fstat,
    output logic                               push,
    output dbs_pkg::entry_t                    entry
);
    import dbs_pkg::*;

    box_t             b;
    logic [CMP_W-1:0] h_e;
    logic [CMP_W-1:0] w_e;

    always_comb
    begin
        b.x = COORD_BITS'(box_x);
        b.y = COORD_BITS'(box_y);
        b.w = COORD_BITS'(box_width);
        b.h = COORD_BITS'(box_height);
        h_e = CMP_W'(b.h);
        w_e = CMP_W'(b.w);
        entry.box  = b;
        entry.last = frame_end;
        entry.pass = (h_e > CMP_W'(cfg.min_h)) && (h_e < CMP_W'(cfg.max_h))
                     && (w_e > (h_e >> 2)) && (w_e < h_e);
    end

    assign in_ready = !fstat.full;
    assign push     = in_valid && !fstat.full;
endmodule
`default_nettype wire

>>> rtl/dbs_fifo.sv
// Short queue between the front end and the back end.
// Depends on dbs_pkg.
`default_nettype none
module dbs_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dbs_pkg::entry_t   wdata,
    input  wire logic              pop,
    output dbs_pkg::entry_t        rdata,
    output dbs_pkg::fifo_stat_t    stat
);
    import dbs_pkg::*;

    entry_t                slot_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0]     wptr_reg;
    logic [FPTR_W-1:0]     rptr_reg;
    logic [FPTR_W:0]       fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= (wptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= (rptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= wdata;
    end

    assign rdata      = slot_reg[rptr_reg];
    assign stat.full  = (fill_reg == (FPTR_W + 1)'(FIFO_DEPTH));
    assign stat.empty = (fill_reg == '0);
endmodule
`default_nettype wire

>>> rtl/dbs_back.sv
// Back end: box store, grouping scan, ordered emission and output register.
// Depends on dbs_pkg.
`default_nettype none
module dbs_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dbs_pkg::cfg_t                 cfg,
    input  wire dbs_pkg::entry_t               qdata,
    input  wire dbs_pkg::fifo_stat_t           fstat,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [dbs_pkg::FIELD_W-1:0]        out_x,
    output logic [dbs_pkg::FIELD_W-1:0]        out_y,
    output logic [dbs_pkg::FIELD_W-1:0]        out_width,
    output logic [dbs_pkg::FIELD_W-1:0]        out_height,
    output logic                               box_valid,
    output logic                               store_overflow,
    output logic                               run_last,
    output dbs_pkg::back_stat_t                stat
);
    import dbs_pkg::*;

    box_t              mem [MAX_BOXES];
    box_t              rdata_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              rdv_reg, rdv_next;
    logic [IDX_W-1:0]  rdj_reg, rdj_next;
    logic [CNT_W-1:0]  gcnt_reg, gcnt_next;
    logic [CNT_W-1:0]  bestn_reg, bestn_next;
    logic [IDX_W-1:0]  bi_reg, bi_next;
    box_t              ref_reg, ref_next;
    box_t              cand_reg, cand_next;
    logic              found_reg, found_next;
    box_t              pend_reg, pend_next;
    logic              pendv_reg, pendv_next;
    logic [COORD_BITS-1:0] prev_reg, prev_next;

    logic              ov_reg, ov_next;
    box_t              obox_reg, obox_next;
    logic              obv_reg, obv_next;
    logic              oovf_reg, oovf_next;
    logic              olast_reg, olast_next;

    logic              out_free;
    logic              member;
    logic [CMP_W-1:0]  thr;
    logic [CNT_W-1:0]  i_plus;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= qdata.box;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            rdv_reg   <= 1'b0;
            found_reg <= 1'b0;
            pendv_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            rdv_reg   <= rdv_next;
            found_reg <= found_next;
            pendv_reg <= pendv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        rdj_reg   <= rdj_next;
        gcnt_reg  <= gcnt_next;
        bestn_reg <= bestn_next;
        bi_reg    <= bi_next;
        ref_reg   <= ref_next;
        cand_reg  <= cand_next;
        pend_reg  <= pend_next;
        prev_reg  <= prev_next;
        obox_reg  <= obox_next;
        obv_reg   <= obv_next;
        oovf_reg  <= oovf_next;
        olast_reg <= olast_next;
    end

    assign out_free = !ov_reg || out_ready;
    assign i_plus   = CNT_W'(i_reg) + 1'b1;
    assign thr      = CMP_W'(prev_reg) + CMP_W'(cfg.min_h >> 1);
    assign member   = (rdj_reg == bi_reg)
                      || ((rdj_reg > bi_reg) && boxes_align(ref_reg, rdata_reg, cfg.align));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        rdv_next   = 1'b0;
        rdj_next   = rdj_reg;
        gcnt_next  = gcnt_reg;
        bestn_next = bestn_reg;
        bi_next    = bi_reg;
        ref_next   = ref_reg;
        cand_next  = cand_reg;
        found_next = found_reg;
        pend_next  = pend_reg;
        pendv_next = pendv_reg;
        prev_next  = prev_reg;
        ov_next    = ov_reg && !out_ready;
        obox_next  = obox_reg;
        obv_next   = obv_reg;
        oovf_next  = oovf_reg;
        olast_next = olast_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = count_reg[IDX_W-1:0];
        rd_en      = 1'b0;
        rd_addr    = j_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (!fstat.empty)
                begin
                    pop = 1'b1;
                    if (qdata.pass)
                    begin
                        if (count_reg < CNT_W'(MAX_BOXES))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (qdata.last)
                    begin
                        i_next     = '0;
                        bestn_next = '0;
                        bi_next    = '0;
                        pendv_next = 1'b0;
                        found_next = 1'b0;
                        prev_next  = '0;
                        state_next = (count_next == '0) ? ST_EPUT : ST_GRD;
                    end
                end
            end
            ST_GRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = ST_GWAIT;
            end
            ST_GWAIT:
            begin
                ref_next   = rdata_reg;
                j_next     = i_plus;
                gcnt_next  = CNT_W'(1);
                state_next = ST_GSCAN;
            end
            ST_GSCAN:
            begin
                if (j_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    rdv_next = 1'b1;
                    rdj_next = j_reg[IDX_W-1:0];
                    j_next   = j_reg + 1'b1;
                end
                if (rdv_reg && boxes_align(ref_reg, rdata_reg, cfg.align))
                    gcnt_next = gcnt_reg + 1'b1;
                if (!(j_reg < count_reg) && !rdv_reg)
                begin
                    if (gcnt_reg > bestn_reg)
                    begin
                        bestn_next = gcnt_reg;
                        bi_next    = i_reg;
                    end
                    i_next     = i_plus[IDX_W-1:0];
                    state_next = (i_plus < count_reg) ? ST_GRD : ST_ERD;
                end
            end
            ST_ERD:
            begin
                rd_en      = 1'b1;
                rd_addr    = bi_reg;
                state_next = ST_EWAIT;
            end
            ST_EWAIT:
            begin
                ref_next   = rdata_reg;
                j_next     = '0;
                found_next = 1'b0;
                state_next = ST_ESCAN;
            end
            ST_ESCAN:
            begin
                if (j_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    rdv_next = 1'b1;
                    rdj_next = j_reg[IDX_W-1:0];
                    j_next   = j_reg + 1'b1;
                end
                if (rdv_reg && member && (CMP_W'(rdata_reg.x) > thr)
                    && (!found_reg || (rdata_reg.x < cand_reg.x)))
                begin
                    cand_next  = rdata_reg;
                    found_next = 1'b1;
                end
                if (!(j_reg < count_reg) && !rdv_reg)
                    state_next = ST_EPUT;
            end
            ST_EPUT:
            begin
                if (out_free)
                begin
                    if (found_reg)
                    begin
                        if (pendv_reg)
                        begin
                            ov_next    = 1'b1;
                            obox_next  = pend_reg;
                            obv_next   = 1'b1;
                            oovf_next  = ovf_reg;
                            olast_next = 1'b0;
                        end
                        pend_next  = cand_reg;
                        pendv_next = 1'b1;
                        prev_next  = cand_reg.x;
                        found_next = 1'b0;
                        j_next     = '0;
                        state_next = ST_ESCAN;
                    end
                    else
                    begin
                        ov_next    = 1'b1;
                        obox_next  = pendv_reg ? pend_reg : '0;
                        obv_next   = pendv_reg;
                        oovf_next  = ovf_reg;
                        olast_next = 1'b1;
                        pendv_next = 1'b0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid      = ov_reg;
    assign out_x          = FIELD_W'(obox_reg.x);
    assign out_y          = FIELD_W'(obox_reg.y);
    assign out_width      = FIELD_W'(obox_reg.w);
    assign out_height     = FIELD_W'(obox_reg.h);
    assign box_valid      = obv_reg;
    assign store_overflow = oovf_reg;
    assign run_last       = olast_reg;
    assign stat.busy      = (state_reg != ST_IDLE);
    assign stat.count     = count_reg;
endmodule
`default_nettype wire

>>> rtl/digit_box_selector.sv
// Top level of the digit box selector: configuration registers, front end,
// queue and back end. Depends on dbs_pkg, dbs_front, dbs_fifo, dbs_back, assert_macros.svh.
//
// channel   direction  handshake             payload
// in        input      in_valid/in_ready     box_x box_y box_width box_height frame_end
// out       output     out_valid/out_ready   out_x out_y out_width out_height box_valid
//                                            store_overflow run_last
// cfg       input      cfg_we                cfg_index cfg_data
//
// While idle, the back end pops a box without frame end and stores it if it passed and the store has room.
// On frame end the back end first groups the stored boxes and then emits its results;
// both phases are set by the single store read port.
// An empty frame goes straight to its one result; a held output stalls each emission step.
// The queue holds two transactions, so the input stalls while a frame is processed.
// Reset clears control state and loads the register defaults; the store needs no clearing.
`default_nettype none
module digit_box_selector (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dbs_pkg::FIELD_W-1:0]   box_x,
    input  wire logic [dbs_pkg::FIELD_W-1:0]   box_y,
    input  wire logic [dbs_pkg::FIELD_W-1:0]   box_width,
    input  wire logic [dbs_pkg::FIELD_W-1:0]   box_height,
    input  wire logic                          frame_end,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [dbs_pkg::FIELD_W-1:0]        out_x,
    output logic [dbs_pkg::FIELD_W-1:0]        out_y,
    output logic [dbs_pkg::FIELD_W-1:0]        out_width,
    output logic [dbs_pkg::FIELD_W-1:0]        out_height,
    output logic                               box_valid,
    output logic                               store_overflow,
    output logic                               run_last,
    input  wire logic                          cfg_we,
    input  wire logic [dbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dbs_pkg::REG_W-1:0]     cfg_data
);
    import dbs_pkg::*;

    `include "assert_macros.svh"

    cfg_t       cfg_reg;
    logic       push;
    logic       pop;
    entry_t     wentry;
    entry_t     rentry;
    fifo_stat_t fstat;
    back_stat_t bstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_h <= MIN_H_RST;
            cfg_reg.max_h <= MAX_H_RST;
            cfg_reg.align <= ALIGN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_H: cfg_reg.min_h <= cfg_data;
                REG_MAX_H: cfg_reg.max_h <= cfg_data;
                REG_ALIGN: cfg_reg.align <= cfg_data;
                default:   cfg_reg       <= cfg_reg;
            endcase
        end
    end

    dbs_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .box_x      (box_x),
        .box_y      (box_y),
        .box_width  (box_width),
        .box_height (box_height),
        .frame_end  (frame_end),
        .cfg        (cfg_reg),
        .fstat      (fstat),
        .push       (push),
        .entry      (wentry)
    );

    dbs_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wentry),
        .pop   (pop),
        .rdata (rentry),
        .stat  (fstat)
    );

    dbs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .qdata          (rentry),
        .fstat          (fstat),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_width      (out_width),
        .out_height     (out_height),
        .box_valid      (box_valid),
        .store_overflow (store_overflow),
        .run_last       (run_last),
        .stat           (bstat)
    );

    `DBS_CHECK(a_count_cap, bstat.count <= CNT_W'(MAX_BOXES))
    `DBS_CHECK(a_no_push_full, !(push && fstat.full))
    `DBS_IMPLY(a_empty_is_last, out_valid && !box_valid, run_last)
    `DBS_IMPLY(a_pop_idle, pop, !bstat.busy && !fstat.empty)
endmodule
`default_nettype wire
